[design/apee_pkg.sv]
// ----------------------------------------------------------------------------
// apee_pkg : shared types and constants of the add/sub parenthesis evaluator
// Token codes, status codes, stack segment kinds and parameter defaults.
// ----------------------------------------------------------------------------
package apee_pkg;

  // parameter defaults
  localparam int DEF_STACK_DEPTH = 32;
  localparam int DEF_VALUE_WIDTH = 32;

  // token kinds carried on the input tuser
  typedef enum logic [2:0] {
    OP_LPAREN = 3'd0,
    OP_RPAREN = 3'd1,
    OP_ADD    = 3'd2,
    OP_SUB    = 3'd3,
    OP_VALUE  = 3'd4,
    OP_END    = 3'd5
  } op_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_INVALID  = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

  // contents of one segment between left parens: nothing, a value,
  // or a value with a pending add or sub above it
  typedef enum logic [1:0] {
    SEG_NONE  = 2'd0,
    SEG_VAL   = 2'd1,
    SEG_VALOP = 2'd2
  } seg_kind_t;

endpackage

[design/add_sub_paren_expression_evaluator.sv]
// ----------------------------------------------------------------------------
// add_sub_paren_expression_evaluator : streaming infix add/sub evaluator
// Folds a token stream of numbers, operators and parentheses into one value
// per expression, with sticky error reporting and a bounded typed stack.
// ----------------------------------------------------------------------------
// One result item leaves for every token item, in order. The block takes one
// item per clock cycle while the output side is not stalled, and each item
// passes an input register and then a result register on its way out.
// The stack is kept as frames split at left
// parens: the open frame (top value and pending operator) and the frame under
// the innermost left paren live in flip-flops, deeper frames sit in a memory
// of STACK_DEPTH words whose registered read prefetches the frame that a
// closing paren brings up next, so every token needs at most one add or
// subtract and no memory read in its own cycle. No clearing pass is needed
// after reset: only frames written since the last end token are ever read.
module add_sub_paren_expression_evaluator
  import apee_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  // token side
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] token_value
  input  logic [2:0]  s_tuser,   // [2:0] opcode
  // result side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] result
  output logic [3:0]  m_tuser    // [2:0] status, [3] done_res
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int EW = VALUE_WIDTH + 3;
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  // input register
  logic              in_valid;
  logic [2:0]        in_op;
  logic signed [31:0] in_tv;

  // stack state
  logic [CW-1:0]     count, count_next;
  logic [CW-1:0]     lpd, lpd_next;
  status_t           sticky, sticky_next;
  seg_kind_t         t_kind, t_kind_next;
  logic              t_sub, t_sub_next;
  logic [VALUE_WIDTH-1:0] t_val, t_val_next;
  seg_kind_t         u_kind;
  logic              u_sub;
  logic [VALUE_WIDTH-1:0] u_val;
  logic [EW-1:0]     p_ent;
  logic [EW-1:0]     mem [STACK_DEPTH];

  // datapath helpers
  logic              advance;
  logic              push_lp, pop_lp;
  status_t           err;
  status_t           out_status;
  logic              out_done;
  logic [31:0]       out_result;
  logic signed [63:0] tv_ext;
  logic [VALUE_WIDTH-1:0] tok_val;
  logic [63:0]       res_ext;
  logic [CW-1:0]     wr_full, rd_full;
  logic [AW-1:0]     wr_idx, rd_idx;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  assign tv_ext  = 64'(in_tv);
  assign tok_val = tv_ext[VALUE_WIDTH-1:0];
  assign res_ext = 64'(t_val);

  assign wr_full = lpd - CW'(1);
  assign rd_full = lpd - CW'(3);
  assign wr_idx  = wr_full[AW-1:0];
  assign rd_idx  = rd_full[AW-1:0];

  // token evaluation
  always_comb begin
    count_next  = count;
    lpd_next    = lpd;
    sticky_next = sticky;
    t_kind_next = t_kind;
    t_sub_next  = t_sub;
    t_val_next  = t_val;
    push_lp     = 1'b0;
    pop_lp      = 1'b0;
    err         = ST_OK;
    out_status  = sticky;
    out_done    = 1'b0;
    out_result  = '0;
    if (in_op == OP_END) begin
      out_done = 1'b1;
      if (sticky == ST_OK) begin
        if (lpd == '0 && t_kind == SEG_VAL) begin
          out_result = res_ext[31:0];
        end else begin
          out_status = ST_INVALID;
        end
      end
      count_next  = '0;
      lpd_next    = '0;
      sticky_next = ST_OK;
      t_kind_next = SEG_NONE;
    end else if (sticky == ST_OK) begin
      unique case (in_op)
        OP_LPAREN: begin
          if (count == FULL) begin
            err = ST_OVERFLOW;
          end else begin
            push_lp     = 1'b1;
            count_next  = count + CW'(1);
            lpd_next    = lpd + CW'(1);
            t_kind_next = SEG_NONE;
          end
        end
        OP_RPAREN: begin
          if (count == '0) begin
            err = ST_INVALID;
          end else if (t_kind == SEG_NONE) begin
            // a left paren is on top
            err = ST_EMPTY;
          end else if (t_kind != SEG_VAL || lpd == '0) begin
            err = ST_INVALID;
          end else if (u_kind == SEG_VAL) begin
            // bracket result would follow a bare value
            err = ST_INVALID;
          end else begin
            pop_lp   = 1'b1;
            lpd_next = lpd - CW'(1);
            if (u_kind == SEG_VALOP) begin
              t_val_next = u_sub ? (u_val - t_val) : (u_val + t_val);
              count_next = count - CW'(3);
            end else begin
              count_next = count - CW'(1);
            end
            t_kind_next = SEG_VAL;
          end
        end
        OP_ADD, OP_SUB: begin
          if (t_kind != SEG_VAL) begin
            err = ST_SHORT;
          end else if (count == FULL) begin
            err = ST_OVERFLOW;
          end else begin
            t_kind_next = SEG_VALOP;
            t_sub_next  = (in_op == OP_SUB);
            count_next  = count + CW'(1);
          end
        end
        OP_VALUE: begin
          if (t_kind == SEG_VAL) begin
            err = ST_INVALID;
          end else if (t_kind == SEG_VALOP) begin
            t_val_next  = t_sub ? (t_val - tok_val) : (t_val + tok_val);
            t_kind_next = SEG_VAL;
            count_next  = count - CW'(1);
          end else if (count == FULL) begin
            err = ST_OVERFLOW;
          end else begin
            t_val_next  = tok_val;
            t_kind_next = SEG_VAL;
            count_next  = count + CW'(1);
          end
        end
        default: err = ST_INVALID;
      endcase
      // a failing token leaves the stack untouched
      if (err != ST_OK) begin
        push_lp     = 1'b0;
        pop_lp      = 1'b0;
        count_next  = count;
        lpd_next    = lpd;
        t_kind_next = t_kind;
        t_sub_next  = t_sub;
        t_val_next  = t_val;
      end
      sticky_next = err;
      out_status  = err;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_op <= s_tuser;
      in_tv <= signed'(s_tdata);
    end
  end

  // control state of the stack
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      lpd    <= '0;
      sticky <= ST_OK;
      t_kind <= SEG_NONE;
    end else if (advance) begin
      count  <= count_next;
      lpd    <= lpd_next;
      sticky <= sticky_next;
      t_kind <= t_kind_next;
    end
  end

  // frame payload, frame under the innermost paren and its prefetch
  always_ff @(posedge clk) begin
    if (advance) begin
      t_sub <= t_sub_next;
      t_val <= t_val_next;
      if (push_lp) begin
        u_kind <= t_kind;
        u_sub  <= t_sub;
        u_val  <= t_val;
        p_ent  <= {u_kind, u_sub, u_val};
      end else if (pop_lp) begin
        u_kind <= seg_kind_t'(p_ent[EW-1 -: 2]);
        u_sub  <= p_ent[VALUE_WIDTH];
        u_val  <= p_ent[VALUE_WIDTH-1:0];
        p_ent  <= mem[rd_idx];
      end
    end
  end

  // deeper frames
  always_ff @(posedge clk) begin
    if (advance && push_lp && lpd != '0) begin
      mem[wr_idx] <= {u_kind, u_sub, u_val};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (advance) begin
      m_tdata <= out_result;
      m_tuser <= {out_done, out_status};
    end
  end

  // checks
  a_lp_within_count: assert property (@(posedge clk) disable iff (rst)
    lpd <= count)
    else $error("left paren count exceeds stack count");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    advance && in_op == OP_END |=> count == '0 && lpd == '0 && sticky == ST_OK)
    else $error("stack not cleared after end token");

  a_result_only_on_ok_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata != '0 |-> m_tuser[3] && m_tuser[2:0] == ST_OK)
    else $error("nonzero result outside a good end token");

endmodule

[dv/add_sub_paren_expression_evaluator_tb.sv]
// ----------------------------------------------------------------------------
// add_sub_paren_expression_evaluator_tb : token stream testbench
// Sends token items in random bursts against a stalling receiver. A stack
// evaluator in the bench predicts every result item that no directed row
// types in, and each result field is checked in order. A directed table
// comes first, then random expressions, some of them broken.
// ----------------------------------------------------------------------------
module add_sub_paren_expression_evaluator_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import apee_pkg::*;

  localparam int DEPTH       = DEF_STACK_DEPTH;
  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEM_TARGET = 440;

  // opcode outside the defined token set
  localparam logic [2:0] OP_BAD_7 = 3'd7;

  // table rows either carry a typed-in verdict or defer to the evaluator
  localparam bit TYPED   = 1'b1;
  localparam bit PREDICT = 1'b0;

  // kinds of entry held on the evaluator stack
  typedef enum logic [1:0] {K_LPAREN, K_ADD, K_SUB, K_VALUE} kind_t;

  typedef struct {
    status_t     status;
    logic        done;
    logic [31:0] result;
  } verdict_t;

  typedef struct {
    logic [2:0]  opc;
    logic [31:0] value;
  } token_t;

  typedef struct {
    logic [2:0]  opc;
    logic [31:0] value;
    bit          typed;
    status_t     status;
    logic        done;
    logic [31:0] result;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // [31:0] token_value
  logic [2:0]  s_tuser;   // [2:0] opcode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;   // [31:0] result
  logic [3:0]  m_tuser;   // [2:0] status, [3] done_res

  add_sub_paren_expression_evaluator DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // directed tokens: extremes, every operation and the short, empty and invalid error cases
  stim_row_t directed_rows [0:25] = '{
    // end on an empty stack
    '{OP_END,    32'h0000_0000, TYPED,   ST_INVALID, 1'b1, 32'h0000_0000},
    // largest plus one wraps to the most negative
    '{OP_VALUE,  32'h7FFF_FFFF, PREDICT, ST_OK,      1'b0, 32'h0000_0000},
    '{OP_ADD,    32'hFFFF_FFFF, PREDICT, ST_OK,      1'b0, 32'h0000_0000},
    '{OP_VALUE,  32'h0000_0001, PREDICT, ST_OK,      1'b0, 32'h0000_0000},
    '{OP_END,    32'h0000_0000, TYPED,   ST_OK,      1'b1, 32'h8000_0000},
    // most negative minus a bracketed difference
    '{OP_VALUE,  32'h8000_0000, PREDICT, ST_OK,      1'b0, 32'h0000_0000},
    '{OP_SUB,    32'h0000_0000, PREDICT, ST_OK,      1'b0, 32'h0000_0000},
    '{OP_LPAREN, 32'h5555_5555, PREDICT, ST_OK,      1'b0, 32'h0000_0000},
    '{OP_VALUE,  32'hFFFF_0000, PREDICT, ST_OK,      1'b0, 32'h0000_0000},
    '{OP_SUB,    32'h0000_0000, PREDICT, ST_OK,      1'b0, 32'h0000_0000},
    '{OP_VALUE,  32'h0001_0000, PREDICT, ST_OK,      1'b0, 32'h0000_0000},
    '{OP_RPAREN, 32'h0000_0000, PREDICT, ST_OK,      1'b0, 32'h0000_0000},
    '{OP_END,    32'hFFFF_FFFF, PREDICT, ST_OK,      1'b0, 32'h0000_0000},
    // empty bracket, then a value ignored while the error holds
    '{OP_LPAREN, 32'h0000_0000, PREDICT, ST_OK,      1'b0, 32'h0000_0000},
    '{OP_RPAREN, 32'h0000_0000, TYPED,   ST_EMPTY,   1'b0, 32'h0000_0000},
    '{OP_VALUE,  32'h1234_5678, TYPED,   ST_EMPTY,   1'b0, 32'h0000_0000},
    '{OP_END,    32'h0000_0000, TYPED,   ST_EMPTY,   1'b1, 32'h0000_0000},
    // operator with no value under it
    '{OP_ADD,    32'h0000_0000, TYPED,   ST_SHORT,   1'b0, 32'h0000_0000},
    '{OP_END,    32'h0000_0000, TYPED,   ST_SHORT,   1'b1, 32'h0000_0000},
    // value straight after a value
    '{OP_VALUE,  32'h0005_0000, PREDICT, ST_OK,      1'b0, 32'h0000_0000},
    '{OP_VALUE,  32'hFFFF_FFFF, TYPED,   ST_INVALID, 1'b0, 32'h0000_0000},
    '{OP_END,    32'h0000_0000, TYPED,   ST_INVALID, 1'b1, 32'h0000_0000},
    // closing bracket on an empty stack
    '{OP_RPAREN, 32'h0000_0000, TYPED,   ST_INVALID, 1'b0, 32'h0000_0000},
    '{OP_END,    32'h0000_0000, TYPED,   ST_INVALID, 1'b1, 32'h0000_0000},
    // undefined opcode
    '{OP_BAD_7,  32'hAAAA_AAAA, TYPED,   ST_INVALID, 1'b0, 32'h0000_0000},
    '{OP_END,    32'h0000_0000, TYPED,   ST_INVALID, 1'b1, 32'h0000_0000}
  };

  // evaluator state
  kind_t       kind_mem [DEPTH];
  logic [31:0] val_mem  [DEPTH];
  int          depth_now = 0;
  status_t     sticky    = ST_OK;
  int          sent_items = 0;

  verdict_t    pending_verdicts [$];
  token_t      expr_tokens [$];
  int          burst_left = 0;
  int          mismatch_count = 0;
  int          cycle_count = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------- evaluator

  function automatic bit top_kind_is(kind_t k);
    return depth_now > 0 && kind_mem[depth_now - 1] == k;
  endfunction

  function automatic status_t stack_push(kind_t k, logic [31:0] v);
    if (depth_now >= DEPTH) return ST_OVERFLOW;
    kind_mem[depth_now] = k;
    val_mem[depth_now]  = v;
    depth_now++;
    return ST_OK;
  endfunction

  // a new value folds into a pending add or sub, or is pushed
  function automatic status_t absorb_value(logic [31:0] v);
    logic [31:0] left;
    logic [31:0] sum;
    if (depth_now == 0 || top_kind_is(K_LPAREN)) return stack_push(K_VALUE, v);
    if ((top_kind_is(K_ADD) || top_kind_is(K_SUB)) && depth_now >= 2) begin
      left = val_mem[depth_now - 2];
      sum  = top_kind_is(K_ADD) ? left + v : left - v;
      depth_now -= 2;
      return stack_push(K_VALUE, sum);
    end
    return ST_INVALID;
  endfunction

  // a closing bracket needs a lone value directly above a left paren
  function automatic status_t close_group();
    int          saved;
    logic [31:0] v;
    status_t     e;
    saved = depth_now;
    if (depth_now == 0) return ST_INVALID;
    if (top_kind_is(K_LPAREN)) return ST_EMPTY;
    if (!top_kind_is(K_VALUE)) return ST_INVALID;
    if (depth_now < 2 || kind_mem[depth_now - 2] != K_LPAREN) return ST_INVALID;
    v = val_mem[depth_now - 1];
    depth_now -= 2;
    e = absorb_value(v);
    // a value left of the bracket makes the fold fail: stack stays as it was
    if (e != ST_OK) depth_now = saved;
    return e;
  endfunction

  // advance the evaluator by one token and give the result item it causes
  function automatic verdict_t fold_token(logic [2:0] opc, logic [31:0] tv);
    verdict_t r;
    status_t  e;
    r.status = ST_OK;
    r.done   = 1'b0;
    r.result = '0;
    if (opc == OP_END) begin
      r.done   = 1'b1;
      r.status = sticky;
      if (sticky == ST_OK) begin
        if (depth_now == 1 && kind_mem[0] == K_VALUE) r.result = val_mem[0];
        else r.status = ST_INVALID;
      end
      depth_now = 0;
      sticky    = ST_OK;
      return r;
    end
    // a set error makes the block ignore every token until end
    if (sticky == ST_OK) begin
      case (opc)
        OP_LPAREN: e = stack_push(K_LPAREN, '0);
        OP_RPAREN: e = close_group();
        OP_ADD:    e = top_kind_is(K_VALUE) ? stack_push(K_ADD, '0) : ST_SHORT;
        OP_SUB:    e = top_kind_is(K_VALUE) ? stack_push(K_SUB, '0) : ST_SHORT;
        OP_VALUE:  e = absorb_value(tv);
        default:   e = ST_INVALID;
      endcase
      sticky = e;
    end
    r.status = sticky;
    return r;
  endfunction

  // ---------------------------------------------------------------- sender

  // one token item, with a random gap whenever a burst runs out
  task automatic send_item(input stim_row_t row);
    verdict_t v;
    @(negedge clk);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 8);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= row.opc;
    s_tdata  <= row.value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    v = fold_token(row.opc, row.value);
    if (row.typed) begin
      v.status = row.status;
      v.done   = row.done;
      v.result = row.result;
    end
    pending_verdicts.push_back(v);
    sent_items++;
    burst_left--;
  endtask

  // stop sending until every result item is back
  task automatic hold_until_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- generator

  task automatic queue_token(input logic [2:0] opc, input logic [31:0] value);
    token_t t;
    t.opc   = opc;
    t.value = value;
    expr_tokens.push_back(t);
  endtask

  // numbers lean towards the extremes and small Q16.16 values
  function automatic logic [31:0] pick_number();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'($urandom_range(0, 16)) << 16;
      4:       return -(32'($urandom_range(0, 16)) << 16);
      default: return $urandom();
    endcase
  endfunction

  task automatic gen_term(input int nest_left);
    if (nest_left > 0 && $urandom_range(0, 3) == 0) begin
      queue_token(OP_LPAREN, $urandom());
      gen_expr(nest_left - 1);
      queue_token(OP_RPAREN, $urandom());
    end else begin
      queue_token(OP_VALUE, pick_number());
    end
  endtask

  // well-formed term list joined by add and sub
  task automatic gen_expr(input int nest_left);
    gen_term(nest_left);
    repeat ($urandom_range(0, 3)) begin
      queue_token($urandom_range(0, 1) ? OP_ADD : OP_SUB, $urandom());
      gen_term(nest_left);
    end
  endtask

  function automatic token_t noise_token();
    token_t t;
    t.opc   = 3'($urandom_range(OP_LPAREN, OP_BAD_7));
    t.value = $urandom();
    return t;
  endfunction

  // one expression and its end token, sometimes broken or deep
  task automatic gen_sequence();
    int pick;
    int idx;
    int levels;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      gen_expr(3);
    end else if (pick < 70) begin
      gen_expr(2);
      idx = $urandom_range(0, expr_tokens.size() - 1);
      case ($urandom_range(0, 2))
        0:       expr_tokens[idx] = noise_token();
        1:       expr_tokens.delete(idx);
        default: expr_tokens.insert(idx, noise_token());
      endcase
    end else if (pick < 85) begin
      // nesting that can fill the stack or run past it
      levels = $urandom_range(8, 34);
      repeat (levels) begin
        if ($urandom_range(0, 1)) begin
          queue_token(OP_VALUE, pick_number());
          queue_token($urandom_range(0, 1) ? OP_ADD : OP_SUB, $urandom());
        end
        queue_token(OP_LPAREN, $urandom());
      end
      gen_expr(0);
      repeat (levels) queue_token(OP_RPAREN, $urandom());
    end else begin
      repeat ($urandom_range(1, 6)) expr_tokens.push_back(noise_token());
    end
    queue_token(OP_END, $urandom());
  endtask

  // ---------------------------------------------------------------- stimulus

  initial begin
    stim_row_t row;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) send_item(directed_rows[i]);
    hold_until_drained();

    // random expressions, with an occasional full drain
    row.typed  = PREDICT;
    while (sent_items < ITEM_TARGET) begin
      gen_sequence();
      foreach (expr_tokens[i]) begin
        row.opc   = expr_tokens[i].opc;
        row.value = expr_tokens[i].value;
        send_item(row);
      end
      expr_tokens.delete();
      if ($urandom_range(0, 24) == 0) hold_until_drained();
    end

    hold_until_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // ---------------------------------------------------------------- receiver

  // stall pattern changes its density whenever the mode age counter wraps
  int stall_left = 0;
  int ready_mode = 0;
  int mode_age   = 0;

  always @(negedge clk) begin
    mode_age++;
    if (mode_age == 64) begin
      mode_age   = 0;
      ready_mode = $urandom_range(0, 2);
    end
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (ready_mode != 0 && $urandom_range(0, 3) < ready_mode) begin
      stall_left = $urandom_range(0, 5);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- checker

  always @(posedge clk) begin
    verdict_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_verdicts.size() == 0) begin
        $error("result item with no token waiting: tuser %0h tdata %0h", m_tuser, m_tdata);
        mismatch_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (m_tuser[2:0] != want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_tuser[2:0]);
          mismatch_count++;
        end
        if (m_tuser[3] != want.done) begin
          $error("done_res: expected %0d, got %0d", want.done, m_tuser[3]);
          mismatch_count++;
        end
        if (m_tdata != want.result) begin
          $error("result: expected %08h, got %08h", want.result, m_tdata);
          mismatch_count++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule

[add_sub_paren_expression_evaluator.f]
design/apee_pkg.sv
design/add_sub_paren_expression_evaluator.sv
dv/add_sub_paren_expression_evaluator_tb.sv
